// ----- design/pstp_pkg.sv -----
// pstp_pkg: shared types and constants for the PE section table parser.
// Used by pstp_ctrl, pstp_datapath and pe_section_table_parser.
package pstp_pkg;

	localparam int HDR_BYTES    = 64;
	localparam int HDR_AW       = $clog2(HDR_BYTES);
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 72;
	localparam int STATUS_W     = 3;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 1'b1;

	typedef enum logic [1:0] {
		PH_MZ,
		PH_PE,
		PH_SEC,
		PH_IDLE
	} phase_t;

	typedef enum logic [1:0] {
		CTL_RUN,
		CTL_CHECK,
		CTL_REPLAY
	} ctl_state_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_SECTION   = 3'd0,
		STS_NONE      = 3'd1,
		STS_BAD_MZ    = 3'd2,
		STS_BAD_PE    = 3'd3,
		STS_BAD_TABLE = 3'd4
	} status_t;

	typedef struct packed {
		logic stream;   // process the accepted input byte
		logic check;    // MZ / PE offset checks after the header store fills
		logic replay;   // process one stored header byte
		logic finish;   // this cycle ends the step of one input request
	} cmd_t;

	typedef struct packed {
		logic mz_end;       // current input byte completes the header store
		logic replay_go;    // checks passed and PE header starts in the store
		logic replay_done;  // replay yields a result or reaches the store end
		logic out_free;     // output register can take a result
	} stat_t;

endpackage

// ----- design/pstp_ctrl.sv -----
// pstp_ctrl: sequencer for the section table parser (run, check, replay).
// Depends on pstp_pkg; drives pstp_datapath through cmd_t, reads stat_t.
module pstp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  pstp_pkg::stat_t stat,
	output pstp_pkg::cmd_t  cmd
);
	import pstp_pkg::*;

	ctl_state_t state_q, state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CTL_RUN: begin
				if (accept && stat.mz_end) begin
					state_d = CTL_CHECK;
				end
			end
			CTL_CHECK: begin
				state_d = stat.replay_go ? CTL_REPLAY : CTL_RUN;
			end
			CTL_REPLAY: begin
				if (stat.replay_done) begin
					state_d = CTL_RUN;
				end
			end
			default: state_d = CTL_RUN;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		accept   = 1'b0;
		cmd      = '0;
		case (state_q)
			CTL_RUN: begin
				s_tready   = stat.out_free;
				accept     = s_tvalid && stat.out_free;
				cmd.stream = accept;
				cmd.finish = accept && !stat.mz_end;
			end
			CTL_CHECK: begin
				cmd.check  = 1'b1;
				cmd.finish = !stat.replay_go;
			end
			CTL_REPLAY: begin
				cmd.replay = 1'b1;
				cmd.finish = stat.replay_done;
			end
			default: ;
		endcase
	end

	a_check_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CTL_CHECK) |-> $past(s_tvalid && s_tready && stat.mz_end))
		else $error("check state without a header fill");

	a_replay_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CTL_REPLAY && $past(state_q) != CTL_REPLAY) |->
		$past(state_q) == CTL_CHECK)
		else $error("replay entered without checks");

endmodule

// ----- design/pstp_datapath.sv -----
// pstp_datapath: header store, header/section field registers, bound checks
// and the output register. Depends on pstp_pkg; sequenced by pstp_ctrl.
module pstp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pstp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pstp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [7:0]                          in_byte,
	input  logic                                in_last,
	input  pstp_pkg::cmd_t                      cmd,
	output pstp_pkg::stat_t                     stat,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pstp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [pstp_pkg::STATUS_W-1:0]       m_tuser,
	output logic                                m_tlast
);
	import pstp_pkg::*;

	localparam int PE_HDR_BYTES  = 24;
	localparam int HDR_NSEC_OFS  = 6;
	localparam int HDR_OPT_OFS   = 20;
	localparam int HDR_LAST_OFS  = 23;
	localparam int ENT_SIZE_OFS  = 8;
	localparam int ENT_ADDR_OFS  = 12;
	localparam int ENT_FLAGS_OFS = 39;
	localparam int ENTRY_BYTES   = 40;
	localparam logic [7:0] MZ_0  = 8'h4D;
	localparam logic [7:0] MZ_1  = 8'h5A;

	function automatic logic [7:0] pe_sig(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0:    v = 8'h50;
			2'd1:    v = 8'h45;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	logic [31:0]       img_base_q, img_size_q;
	logic [31:0]       pos_q;
	phase_t            phase_q, phase_d;
	logic [31:0]       pe_pos_q, pe_pos_d;
	logic [15:0]       total_q, total_d;
	logic [15:0]       opt_q, opt_d;
	logic [15:0]       done_q, done_d;
	logic [31:0]       esize_q, esize_d;
	logic [31:0]       eaddr_q, eaddr_d;
	logic              hdr_act_q, hdr_act_d;
	logic [4:0]        k_q, k_d;
	logic              sec_act_q, sec_act_d;
	logic [5:0]        entry_q, entry_d;
	logic [31:0]       tstart_q, tstart_d;
	logic              mz0_q, mz0_d, mz1_q, mz1_d;
	logic              last_q;
	logic [HDR_AW-1:0] rep_q;
	logic [7:0]        rd_q;
	logic [33:0]       table_q;
	logic [21:0]       tot40_q;

	logic [7:0]        mem [HDR_BYTES];
	logic [HDR_AW-1:0] rd_addr;
	logic              store_we;

	logic              m_valid_q, m_last_q, m_x_q, m_w_q;
	logic [31:0]       m_addr_q, m_size_q;
	status_t           m_sts_q;

	logic [31:0]       p;
	logic [7:0]        b;
	logic [4:0]        k;
	logic [15:0]       done_inc;
	logic [33:0]       tbl_end;
	logic              check_ok;
	logic              cand_v, cand_x, cand_w, cand_last;
	status_t           cand_sts;
	logic [31:0]       cand_addr, cand_size;
	logic              lastf, clear, out_we, override;

	always_comb begin
		p        = cmd.replay ? {{(32-HDR_AW){1'b0}}, rep_q} : pos_q;
		b        = cmd.replay ? rd_q : in_byte;
		k        = hdr_act_q ? k_q : 5'd0;
		done_inc = done_q + 16'd1;
		tbl_end  = table_q + {12'b0, tot40_q};
		check_ok = 1'b0;

		phase_d   = phase_q;
		pe_pos_d  = pe_pos_q;
		total_d   = total_q;
		opt_d     = opt_q;
		done_d    = done_q;
		esize_d   = esize_q;
		eaddr_d   = eaddr_q;
		hdr_act_d = hdr_act_q;
		k_d       = k_q;
		sec_act_d = sec_act_q;
		entry_d   = entry_q;
		tstart_d  = tstart_q;
		mz0_d     = mz0_q;
		mz1_d     = mz1_q;

		cand_v    = 1'b0;
		cand_sts  = STS_SECTION;
		cand_addr = '0;
		cand_size = '0;
		cand_x    = 1'b0;
		cand_w    = 1'b0;
		cand_last = 1'b0;

		if (cmd.check) begin
			if (img_size_q < 32'(HDR_BYTES) || !mz0_q || !mz1_q) begin
				phase_d   = PH_IDLE;
				cand_v    = 1'b1;
				cand_sts  = STS_BAD_MZ;
				cand_last = 1'b1;
			end else if (({1'b0, pe_pos_q} + 33'(PE_HDR_BYTES)) > {1'b0, img_size_q}) begin
				phase_d   = PH_IDLE;
				cand_v    = 1'b1;
				cand_sts  = STS_BAD_PE;
				cand_last = 1'b1;
			end else begin
				check_ok  = 1'b1;
				phase_d   = PH_PE;
				hdr_act_d = 1'b0;
				k_d       = 5'd0;
			end
		end else if (cmd.stream || cmd.replay) begin
			case (phase_q)
				PH_MZ: begin
					if (pos_q[31:HDR_AW] == '0) begin
						if (pos_q[HDR_AW-1:0] == HDR_AW'(0)) begin
							mz0_d = (b == MZ_0);
						end
						if (pos_q[HDR_AW-1:0] == HDR_AW'(1)) begin
							mz1_d = (b == MZ_1);
						end
						// PE offset lives in the last four stored bytes
						if (pos_q[HDR_AW-1:2] == '1) begin
							pe_pos_d[{pos_q[1:0], 3'b000} +: 8] = b;
						end
					end
				end
				PH_PE: begin
					if (hdr_act_q || p == pe_pos_q) begin
						hdr_act_d = 1'b1;
						k_d       = k + 5'd1;
						if (k < 5'd4 && b != pe_sig(k[1:0])) begin
							phase_d   = PH_IDLE;
							cand_v    = 1'b1;
							cand_sts  = STS_BAD_PE;
							cand_last = 1'b1;
						end else begin
							case (k)
								5'(HDR_NSEC_OFS):     total_d[7:0]  = b;
								5'(HDR_NSEC_OFS + 1): total_d[15:8] = b;
								5'(HDR_OPT_OFS):      opt_d[7:0]    = b;
								5'(HDR_OPT_OFS + 1):  opt_d[15:8]   = b;
								5'(HDR_LAST_OFS): begin
									if (tbl_end > {2'b00, img_size_q}) begin
										phase_d   = PH_IDLE;
										cand_v    = 1'b1;
										cand_sts  = STS_BAD_TABLE;
										cand_last = 1'b1;
									end else if (total_q == 16'd0) begin
										phase_d   = PH_IDLE;
										cand_v    = 1'b1;
										cand_sts  = STS_NONE;
										cand_last = 1'b1;
									end else begin
										phase_d   = PH_SEC;
										tstart_d  = table_q[31:0];
										done_d    = 16'd0;
										entry_d   = 6'd0;
										sec_act_d = 1'b0;
									end
								end
								default: ;
							endcase
						end
					end
				end
				PH_SEC: begin
					if (sec_act_q || p == tstart_q) begin
						sec_act_d = 1'b1;
						entry_d   = entry_q + 6'd1;
						if (entry_q >= 6'(ENT_SIZE_OFS) && entry_q < 6'(ENT_ADDR_OFS)) begin
							esize_d[{entry_q[1:0], 3'b000} +: 8] = b;
						end else if (entry_q >= 6'(ENT_ADDR_OFS) &&
							entry_q < 6'(ENT_ADDR_OFS + 4)) begin
							eaddr_d[{entry_q[1:0], 3'b000} +: 8] = b;
						end
						if (entry_q == 6'(ENT_FLAGS_OFS)) begin
							done_d    = done_inc;
							cand_v    = 1'b1;
							cand_sts  = STS_SECTION;
							cand_addr = img_base_q + eaddr_q;
							cand_size = esize_q;
							cand_x    = b[5];
							cand_w    = b[7];
							cand_last = (done_inc == total_q);
							if (done_inc == total_q) begin
								phase_d = PH_IDLE;
							end
							entry_d = 6'd0;
							esize_d = '0;
							eaddr_d = '0;
						end
					end
				end
				default: ;
			endcase
		end

		// end of a request: an image end before the final result reports short image
		lastf    = cmd.stream ? in_last : last_q;
		clear    = cmd.finish && lastf;
		override = lastf && (phase_d != PH_IDLE || !cand_last);
		out_we   = cmd.finish && (cand_v || (lastf && phase_d != PH_IDLE));
	end

	assign store_we = cmd.stream && phase_q == PH_MZ && pos_q[31:HDR_AW] == '0;
	assign rd_addr  = cmd.check ? pe_pos_q[HDR_AW-1:0] : rep_q + HDR_AW'(1);

	always_ff @(posedge clk) begin
		if (store_we) begin
			mem[pos_q[HDR_AW-1:0]] <= in_byte;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_base_q <= '0;
			img_size_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_BASE: img_base_q <= cfg_data;
				CFG_IMAGE_SIZE: img_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			phase_q   <= PH_MZ;
			pe_pos_q  <= '0;
			total_q   <= '0;
			opt_q     <= '0;
			done_q    <= '0;
			esize_q   <= '0;
			eaddr_q   <= '0;
			hdr_act_q <= 1'b0;
			k_q       <= '0;
			sec_act_q <= 1'b0;
			entry_q   <= '0;
			tstart_q  <= '0;
			mz0_q     <= 1'b0;
			mz1_q     <= 1'b0;
			last_q    <= 1'b0;
			rep_q     <= '0;
		end else if (clear) begin
			pos_q     <= '0;
			phase_q   <= PH_MZ;
			pe_pos_q  <= '0;
			total_q   <= '0;
			opt_q     <= '0;
			done_q    <= '0;
			esize_q   <= '0;
			eaddr_q   <= '0;
			hdr_act_q <= 1'b0;
			k_q       <= '0;
			sec_act_q <= 1'b0;
			entry_q   <= '0;
			tstart_q  <= '0;
			mz0_q     <= 1'b0;
			mz1_q     <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			pe_pos_q  <= pe_pos_d;
			total_q   <= total_d;
			opt_q     <= opt_d;
			done_q    <= done_d;
			esize_q   <= esize_d;
			eaddr_q   <= eaddr_d;
			hdr_act_q <= hdr_act_d;
			k_q       <= k_d;
			sec_act_q <= sec_act_d;
			entry_q   <= entry_d;
			tstart_q  <= tstart_d;
			mz0_q     <= mz0_d;
			mz1_q     <= mz1_d;
			if (cmd.stream) begin
				pos_q  <= pos_q + 32'd1;
				last_q <= in_last;
			end
			if (cmd.check) begin
				rep_q <= pe_pos_q[HDR_AW-1:0];
			end else if (cmd.replay) begin
				rep_q <= rep_q + HDR_AW'(1);
			end
		end
	end

	// table start and table length are registered from their sources
	always_ff @(posedge clk) begin
		table_q <= {2'b00, pe_pos_q} + 34'(PE_HDR_BYTES) + {18'b0, opt_q};
		tot40_q <= 22'(total_q) * 22'(ENTRY_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_we) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			m_addr_q <= override ? 32'd0 : cand_addr;
			m_size_q <= override ? 32'd0 : cand_size;
			m_x_q    <= override ? 1'b0 : cand_x;
			m_w_q    <= override ? 1'b0 : cand_w;
			m_sts_q  <= override ? STS_BAD_MZ : cand_sts;
			m_last_q <= override ? 1'b1 : cand_last;
		end
	end

	assign stat.mz_end      = phase_q == PH_MZ && pos_q == 32'(HDR_BYTES - 1);
	assign stat.replay_go   = check_ok && pe_pos_q[31:HDR_AW] == '0;
	assign stat.replay_done = cand_v || rep_q == '1;
	assign stat.out_free    = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, m_w_q, m_x_q, m_size_q, m_addr_q};
	assign m_tuser  = m_sts_q;
	assign m_tlast  = m_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_we && m_valid_q && !m_tready))
		else $error("result written over a pending one");

	a_done_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEC) |-> (done_q < total_q))
		else $error("section count past table size");

	a_replay_not_mz: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.replay |-> (phase_q == PH_PE || phase_q == PH_SEC))
		else $error("replay outside header or table phase");

endmodule

// ----- design/pe_section_table_parser.sv -----
// pe_section_table_parser: top level of the PE/COFF section table parser.
// Depends on pstp_pkg, pstp_ctrl and pstp_datapath.
//
// Usage: write image_base (index 0) and image_size (index 1) on the cfg port
// while idle, then stream the image on s_* one byte per request, offsets from
// zero, with s_tlast on the final byte. Each request on m_* is one section
// record (m_tuser = 0) or a status (1 no sections, 2 bad MZ or short image,
// 3 bad PE header, 4 table outside image); m_tlast marks the last one.
// Throughput: one byte per cycle while no result waits on m_tready. After
// the byte at offset 63 the parser runs the MZ and PE offset checks and,
// when the PE header starts inside the first 64 bytes at offset P, replays
// the stored bytes from P on out of the header store, one per cycle, until
// a result or the store end. A result is registered and shows on m_tvalid
// the cycle after the byte, check or replay step that completes it.
// Reset clears all parser state and both configuration registers; the store
// needs no clearing. When m_tready is low with a result pending, s_tready
// drops until that result is taken.
module pe_section_table_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pstp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pstp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pstp_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
	input  logic                                s_tlast,   // last_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pstp_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [31:0] section_address,
	                                                       // [63:32] section_size,
	                                                       // [64] executable, [65] writable
	output logic [pstp_pkg::STATUS_W-1:0]       m_tuser,   // [2:0] status
	output logic                                m_tlast    // last_result
);
	import pstp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pstp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pstp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
